// ===== src/gbc_pkg.sv =====
// shared types and constants of the 3x3 gaussian blur core
`timescale 1ns / 1ps
package gbc_pkg;

	localparam int PIX_W     = 8;
	localparam int COL_W     = 12;
	localparam int ROW_W     = 12;
	localparam int OUT_COL_W = 10;
	localparam int NRES      = 4;

	// configuration register indexes
	localparam int REG_WIDTH  = 0;
	localparam int REG_HEIGHT = 1;

	// result kinds, also bit positions in the result mask
	localparam int RES_INNER       = 0;
	localparam int RES_RIGHT       = 1;
	localparam int RES_BOTTOM      = 2;
	localparam int RES_BOTTOM_RIGHT = 3;

	typedef logic [PIX_W-1:0] pix_t;
	typedef logic [NRES-1:0]  res_mask_t;

	typedef struct packed {
		pix_t             pix;
		pix_t             top;
		pix_t             mid;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		res_mask_t        mask;
	} win_item_t;

endpackage

// ===== src/gaussian_blur_3x3_clamped_core.sv =====
// top level of the 3x3 gaussian blur core: config registers, counters, read stage
// path: an accepted item passes the read stage and the window registers before its results reach the output register
// throughput: one item per cycle while out_stall is low and each item causes at most one
// result; an item with more results holds the window stage while the output register takes
// one result per cycle, out_stall allowing (row ends and the last row cause two to four)
// reset: clears counters, window and pending results, sets size to 640 x 480; line stores
// are not cleared and need no clearing pass
`timescale 1ns / 1ps
module gaussian_blur_3x3_clamped_core
	import gbc_pkg::*;
#(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [2:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     blurred,
	output logic [OUT_COL_W-1:0] out_col,
	output logic [ROW_W-1:0]     out_row,
	output logic                 run_last,
	output logic                 frame_end
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [12:0] MAXW = 13'(MAX_WIDTH);

	logic [10:0]    width_q;
	logic [11:0]    height_q;
	logic [CW-1:0]  col_q;
	logic [ROW_W-1:0] row_q;

	logic [12:0]      w_ext;
	logic [12:0]      w_eff;
	logic [CW-1:0]    wm1;
	logic [ROW_W-1:0] hm1;
	logic [CW-1:0]    c;
	logic [ROW_W-1:0] r;
	res_mask_t        mask;
	logic             cfg_wr;
	logic             in_acc;
	logic             xfer;
	logic             win_ready;

	logic             s1_valid;
	pix_t             pix_s1;
	logic [CW-1:0]    col_s1;
	logic [ROW_W-1:0] row_s1;
	res_mask_t        mask_s1;
	logic             byp_s1;
	pix_t             byp_older_s1;
	pix_t             byp_newer_s1;

	pix_t      rd_older;
	pix_t      rd_newer;
	pix_t      top_eff;
	pix_t      mid_eff;
	win_item_t item;

	// configuration port
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd640;
			height_q <= 12'd480;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				1'(REG_WIDTH):  width_q  <= pwdata[10:0];
				1'(REG_HEIGHT): height_q <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			1'(REG_WIDTH):  prdata = 32'(width_q);
			1'(REG_HEIGHT): prdata = 32'(height_q);
			default:        prdata = '0;
		endcase
	end

	// clamped position of the incoming item
	always_comb begin
		w_ext = 13'(width_q);
		if (w_ext == '0) begin
			w_eff = 13'd1;
		end else if (w_ext > MAXW) begin
			w_eff = MAXW;
		end else begin
			w_eff = w_ext;
		end
		wm1 = CW'(w_eff - 13'd1);
		hm1 = (height_q == '0) ? '0 : height_q - 12'd1;
		c   = (13'(col_q) < w_eff) ? col_q : wm1;
		r   = (row_q > hm1) ? hm1 : row_q;
		mask = '0;
		mask[RES_INNER]        = (r != '0) && (c != '0);
		mask[RES_RIGHT]        = (r != '0) && (c == wm1);
		mask[RES_BOTTOM]       = (r == hm1) && (c != '0);
		mask[RES_BOTTOM_RIGHT] = (r == hm1) && (c == wm1);
	end

	assign xfer     = s1_valid && win_ready;
	assign in_stall = s1_valid && !xfer;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (c >= wm1) begin
				col_q <= '0;
				row_q <= (r >= hm1) ? '0 : r + ROW_W'(1);
			end else begin
				col_q <= c + CW'(1);
				row_q <= r;
			end
		end
	end

	// read stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (in_acc) begin
			s1_valid <= 1'b1;
			byp_s1   <= s1_valid && (col_s1 == c);
		end else if (xfer) begin
			s1_valid <= 1'b0;
			byp_s1   <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1       <= pixel_in;
			col_s1       <= c;
			row_s1       <= r;
			mask_s1      <= mask;
			byp_older_s1 <= mid_eff;
			byp_newer_s1 <= pix_s1;
		end
	end

	gbc_line_buf #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_buf (
		.clk      (clk),
		.rd_en    (in_acc),
		.rd_addr  (c),
		.wr_en    (xfer),
		.wr_addr  (col_s1),
		.wr_older (mid_eff),
		.wr_newer (pix_s1),
		.rd_older (rd_older),
		.rd_newer (rd_newer)
	);

	// first row replicates the pixel upward
	always_comb begin
		if (row_s1 == '0) begin
			top_eff = pix_s1;
			mid_eff = pix_s1;
		end else if (byp_s1) begin
			top_eff = byp_older_s1;
			mid_eff = byp_newer_s1;
		end else begin
			top_eff = rd_older;
			mid_eff = rd_newer;
		end
		item.pix  = pix_s1;
		item.top  = top_eff;
		item.mid  = mid_eff;
		item.col  = COL_W'(col_s1);
		item.row  = row_s1;
		item.mask = mask_s1;
	end

	gbc_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (xfer),
		.item      (item),
		.ready     (win_ready),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.blurred   (blurred),
		.out_col   (out_col),
		.out_row   (out_row),
		.run_last  (run_last),
		.frame_end (frame_end)
	);

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_valid |-> xfer)
		else $error("read stage overwritten before hand-off");

	a_bypass_valid: assert property (@(posedge clk) disable iff (!arst_n)
		byp_s1 |-> s1_valid)
		else $error("bypass set without an item in the read stage");

	a_bypass_addr: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s1_valid && (col_s1 == c) |=> byp_s1)
		else $error("same-address item missed the bypass");

endmodule

// ===== src/gbc_line_buf.sv =====
// two line stores with registered read and a shared address per port
`timescale 1ns / 1ps
module gbc_line_buf
	import gbc_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pix_t          wr_older,
	input  pix_t          wr_newer,
	output pix_t          rd_older,
	output pix_t          rd_newer
);

	pix_t mem_older [DEPTH];
	pix_t mem_newer [DEPTH];
	pix_t rd_older_q;
	pix_t rd_newer_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_older[wr_addr] <= wr_older;
			mem_newer[wr_addr] <= wr_newer;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_older_q <= mem_older[rd_addr];
			rd_newer_q <= mem_newer[rd_addr];
		end
	end

	assign rd_older = rd_older_q;
	assign rd_newer = rd_newer_q;

endmodule

// ===== src/gbc_window.sv =====
// 3x3 window registers, result sequencing and output register
`timescale 1ns / 1ps
module gbc_window
	import gbc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  win_item_t            item,
	output logic                 ready,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [PIX_W-1:0]     blurred,
	output logic [OUT_COL_W-1:0] out_col,
	output logic [ROW_W-1:0]     out_row,
	output logic                 run_last,
	output logic                 frame_end
);

	pix_t             win_q [3][3];
	res_mask_t        mask_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic                 out_valid_q;
	pix_t                 blurred_q;
	logic [OUT_COL_W-1:0] out_col_q;
	logic [ROW_W-1:0]     out_row_q;
	logic                 run_last_q;
	logic                 frame_end_q;

	res_mask_t        pick;
	res_mask_t        rest;
	logic [1:0]       kind;
	logic             out_load;
	pix_t             row_in [3];
	logic [9:0]       row_sum [3];
	logic [11:0]      sum;
	logic [COL_W-1:0] col_sel;
	logic [ROW_W-1:0] row_sel;

	assign pick = mask_q & (~mask_q + res_mask_t'(1));
	assign rest = mask_q & ~pick;

	always_comb begin
		kind = 2'(RES_INNER);
		case (1'b1)
			pick[RES_INNER]:        kind = 2'(RES_INNER);
			pick[RES_RIGHT]:        kind = 2'(RES_RIGHT);
			pick[RES_BOTTOM]:       kind = 2'(RES_BOTTOM);
			pick[RES_BOTTOM_RIGHT]: kind = 2'(RES_BOTTOM_RIGHT);
			default:                kind = 2'(RES_INNER);
		endcase
	end

	assign out_load = (|mask_q) && (!out_valid_q || !out_stall);
	assign ready    = (mask_q == '0) || (out_load && $onehot(mask_q));

	// kind bit 0 replicates the right column, bit 1 replicates the bottom row
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (kind[0]) begin
				row_sum[i] = 10'(win_q[i][1]) + {1'b0, win_q[i][2], 1'b0}
					+ 10'(win_q[i][2]);
			end else begin
				row_sum[i] = 10'(win_q[i][0]) + {1'b0, win_q[i][1], 1'b0}
					+ 10'(win_q[i][2]);
			end
		end
		if (kind[1]) begin
			sum = 12'(row_sum[1]) + {1'b0, row_sum[2], 1'b0} + 12'(row_sum[2]);
		end else begin
			sum = 12'(row_sum[0]) + {1'b0, row_sum[1], 1'b0} + 12'(row_sum[2]);
		end
		col_sel = kind[0] ? col_q : col_q - COL_W'(1);
		row_sel = kind[1] ? row_q : row_q - ROW_W'(1);
	end

	assign row_in[0] = item.top;
	assign row_in[1] = item.mid;
	assign row_in[2] = item.pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
			mask_q <= '0;
		end else if (load) begin
			for (int i = 0; i < 3; i++) begin
				if (item.col == '0) begin
					win_q[i][0] <= row_in[i];
					win_q[i][1] <= row_in[i];
				end else begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[i][2] <= row_in[i];
			end
			mask_q <= item.mask;
		end else if (out_load) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q <= item.col;
			row_q <= item.row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			blurred_q   <= sum[11:4];
			out_col_q   <= col_sel[OUT_COL_W-1:0];
			out_row_q   <= row_sel;
			run_last_q  <= (rest == '0);
			frame_end_q <= (kind == 2'(RES_BOTTOM_RIGHT));
		end
	end

	assign out_valid = out_valid_q;
	assign blurred   = blurred_q;
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign run_last  = run_last_q;
	assign frame_end = frame_end_q;

	a_load_when_ready: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("window loaded while results still pending");

	a_pick_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(pick) && ((mask_q != '0) == $onehot(pick)))
		else $error("result pick is not a single kind");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> run_last_q)
		else $error("frame end result is not the last of its item");

endmodule
